// ----- hw/rtl/wscfe_pkg.sv -----
// Shared types, constants and helpers for the client frame encoder.
// No dependencies; imported by websocket_client_frame_encoder_unit.
`timescale 1ns / 1ps

package wscfe_pkg;

   // Frame header constants
   localparam logic [7:0]  HDR_FIN_TEXT   = 8'h81;
   localparam logic [7:0]  HDR_MASK_BIT   = 8'h80;
   localparam logic [19:0] SHORT_LEN_MAX  = 20'd125;
   localparam logic [6:0]  EXT_LEN_16     = 7'd126;
   localparam logic [19:0] MAX_PAYLOAD    = 20'd65535;

   // Header bytes queued behind the first one: 126, two length bytes, four key bytes
   localparam int          HDR_DEPTH      = 7;
   localparam logic [2:0]  HDR_CNT_SHORT  = 3'd5;
   localparam logic [2:0]  HDR_CNT_LONG   = 3'd7;

   // Status codes
   localparam logic [1:0]  STATUS_OK       = 2'd0;
   localparam logic [1:0]  STATUS_TOO_LONG = 2'd1;
   localparam logic [1:0]  STATUS_NO_FRAME = 2'd2;

   // Input mode codes
   localparam logic        MODE_START   = 1'b0;
   localparam logic        MODE_PAYLOAD = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [1:0] status;
   } result_type;

   // Key byte by position, first key byte in the top bits
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [7:0] kb;
      case (idx)
         2'd0:    kb = key[31:24];
         2'd1:    kb = key[23:16];
         2'd2:    kb = key[15:8];
         default: kb = key[7:0];
      endcase
      return kb;
   endfunction

endpackage

// ----- hw/rtl/websocket_client_frame_encoder_unit.sv -----
// Masked client text-frame encoder, top level.
// Depends on wscfe_pkg for header constants, status codes and the result type.
`timescale 1ns / 1ps

// Usage
//   req_* channel: one transfer per item. req_mode 0 opens a frame with
//   req_frame_length and req_mask_key; req_mode 1 carries one req_payload_byte.
//   rsp_* channel: one transfer per frame byte (header, key, masked payload),
//   with rsp_frame_end on the last byte of the frame and rsp_status for errors.
// An accepted item lands in an input register, and its first result is
//   registered in the output register once that register is free and no
//   header bytes of an earlier frame are still queued.
// Throughput: a payload byte or an error item yields one result, so payload
//   streams at one byte per cycle while rsp_stall is low. A start item yields
//   6 header bytes for lengths up to 125 and 8 for longer ones, sent through
//   the header queue at one byte per cycle while the output register is free.
// The input register takes a new transfer while a result waits in the output
//   register, so one item is buffered under a receiver stall.
// Reset (synchronous, active high) empties both registers and the header
//   queue and closes any open frame with a zero key.
// When the receiver asserts rsp_stall, the output register holds its byte,
//   the header queue holds, and req_stall rises once the input register is full.
module websocket_client_frame_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [19:0] req_frame_length,
   input  logic [31:0] req_mask_key,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_status
);
   import wscfe_pkg::*;

   // Input register
   logic        in_valid_ff, in_valid_in;
   logic        in_mode_ff;
   logic [19:0] in_len_ff;
   logic [31:0] in_key_ff;
   logic [7:0]  in_pb_ff;

   // Frame state
   logic        frame_open_ff, frame_open_in;
   logic [31:0] key_store_ff, key_store_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  key_index_ff, key_index_in;

   // Header queue: bytes still to send after the one in the output register
   logic [7:0]  hdr_ff [HDR_DEPTH];
   logic [7:0]  hdr_in [HDR_DEPTH];
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic        zero_len_ff, zero_len_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic out_free;
   logic hdr_busy;
   logic take_hdr;
   logic take_in;

   // Output register can load when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign hdr_busy  = (hdr_cnt_ff != 3'd0);
   // Header bytes of the current frame go out before the next item
   assign take_hdr  = out_free && hdr_busy;
   assign take_in   = out_free && !hdr_busy && in_valid_ff;
   assign req_stall = in_valid_ff && !take_in;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      frame_open_in = frame_open_ff;
      key_store_in  = key_store_ff;
      bytes_left_in = bytes_left_ff;
      key_index_in  = key_index_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      zero_len_in   = zero_len_ff;
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (out_free) begin
         rsp_valid_in = take_hdr || take_in;
      end

      if (take_hdr) begin
         // Advance the queue by one byte; the last one may close a zero-length frame
         rsp_in.out_byte  = hdr_ff[0];
         rsp_in.frame_end = (hdr_cnt_ff == 3'd1) && zero_len_ff;
         rsp_in.status    = STATUS_OK;
         for (int i = 0; i < HDR_DEPTH - 1; i++) begin
            hdr_in[i] = hdr_ff[i + 1];
         end
         hdr_in[HDR_DEPTH - 1] = 8'h00;
         hdr_cnt_in = hdr_cnt_ff - 3'd1;
      end else if (take_in) begin
         if (in_mode_ff == MODE_START) begin
            if (in_len_ff > MAX_PAYLOAD) begin
               // Reject and drop any open frame
               frame_open_in    = 1'b0;
               rsp_in.out_byte  = 8'h00;
               rsp_in.frame_end = 1'b0;
               rsp_in.status    = STATUS_TOO_LONG;
            end else begin
               rsp_in.out_byte  = HDR_FIN_TEXT;
               rsp_in.frame_end = 1'b0;
               rsp_in.status    = STATUS_OK;
               if (in_len_ff <= SHORT_LEN_MAX) begin
                  hdr_in[0]  = HDR_MASK_BIT | {1'b0, in_len_ff[6:0]};
                  hdr_in[1]  = in_key_ff[31:24];
                  hdr_in[2]  = in_key_ff[23:16];
                  hdr_in[3]  = in_key_ff[15:8];
                  hdr_in[4]  = in_key_ff[7:0];
                  hdr_in[5]  = 8'h00;
                  hdr_in[6]  = 8'h00;
                  hdr_cnt_in = HDR_CNT_SHORT;
               end else begin
                  hdr_in[0]  = HDR_MASK_BIT | {1'b0, EXT_LEN_16};
                  hdr_in[1]  = in_len_ff[15:8];
                  hdr_in[2]  = in_len_ff[7:0];
                  hdr_in[3]  = in_key_ff[31:24];
                  hdr_in[4]  = in_key_ff[23:16];
                  hdr_in[5]  = in_key_ff[15:8];
                  hdr_in[6]  = in_key_ff[7:0];
                  hdr_cnt_in = HDR_CNT_LONG;
               end
               zero_len_in   = (in_len_ff == 20'd0);
               key_store_in  = in_key_ff;
               key_index_in  = 2'd0;
               bytes_left_in = in_len_ff[15:0];
               frame_open_in = (in_len_ff != 20'd0);
            end
         end else if (!frame_open_ff) begin
            rsp_in.out_byte  = 8'h00;
            rsp_in.frame_end = 1'b0;
            rsp_in.status    = STATUS_NO_FRAME;
         end else begin
            // Mask the payload byte and count it off
            rsp_in.out_byte  = in_pb_ff ^ key_byte(key_store_ff, key_index_ff);
            rsp_in.frame_end = (bytes_left_ff == 16'd1);
            rsp_in.status    = STATUS_OK;
            key_index_in     = key_index_ff + 2'd1;
            bytes_left_in    = bytes_left_ff - 16'd1;
            if (bytes_left_ff == 16'd1) begin
               frame_open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hdr_cnt_ff    <= 3'd0;
         zero_len_ff   <= 1'b0;
         frame_open_ff <= 1'b0;
         key_store_ff  <= 32'd0;
         bytes_left_ff <= 16'd0;
         key_index_ff  <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         zero_len_ff   <= zero_len_in;
         frame_open_ff <= frame_open_in;
         key_store_ff  <= key_store_in;
         bytes_left_ff <= bytes_left_in;
         key_index_ff  <= key_index_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_mode_ff <= req_mode;
         in_len_ff  <= req_frame_length;
         in_key_ff  <= req_mask_key;
         in_pb_ff   <= req_payload_byte;
      end
      rsp_ff <= rsp_in;
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_ff[i] <= hdr_in[i];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_ff.out_byte;
   assign rsp_frame_end = rsp_ff.frame_end;
   assign rsp_status    = rsp_ff.status;

endmodule
